// File: hw/rtl/yuvrgb_pkg.sv
// Package with the item types, the conversion constants and the channel clamp for the converter.
`timescale 1ns / 1ps

package yuvrgb_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned ChanW   = 10;
  localparam int unsigned SumW    = 25;
  localparam int unsigned CorrW   = 8;
  localparam int unsigned NumLuma = 4;

  localparam logic signed [8:0]      CHROMA_BIAS = 9'sd128;
  localparam logic signed [SumW-1:0] GAIN_U      = 25'sd12727;
  localparam logic signed [SumW-1:0] GAIN_V      = 25'sd33384;
  localparam logic signed [SumW-1:0] ROUND_HALF  = 25'sd32768;
  localparam logic signed [ChanW-1:0] PIXEL_MAX  = 10'sd255;

  typedef struct packed {
    logic [SampleW-1:0] u_sample;
    logic [SampleW-1:0] luma_0;
    logic [SampleW-1:0] luma_1;
    logic [SampleW-1:0] v_sample;
    logic [SampleW-1:0] luma_2;
    logic [SampleW-1:0] luma_3;
  } group_t;

  typedef struct packed {
    logic [SampleW-1:0] red_0;
    logic [SampleW-1:0] green_0;
    logic [SampleW-1:0] blue_0;
    logic [SampleW-1:0] red_1;
    logic [SampleW-1:0] green_1;
    logic [SampleW-1:0] blue_1;
    logic [SampleW-1:0] red_2;
    logic [SampleW-1:0] green_2;
    logic [SampleW-1:0] blue_2;
    logic [SampleW-1:0] red_3;
    logic [SampleW-1:0] green_3;
    logic [SampleW-1:0] blue_3;
  } pixels_t;

  // Saturates a signed channel value to the 0..255 range of a color byte.
  function automatic logic [SampleW-1:0] clamp_chan(input logic signed [ChanW-1:0] x);
    logic [SampleW-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > PIXEL_MAX) begin
      res = '1;
    end else begin
      res = x[SampleW-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/yuvrgb_convert.sv
// Combinational conversion of one YUV 4:1:1 group into four clamped RGB pixels.
`timescale 1ns / 1ps

module yuvrgb_convert (
  input  yuvrgb_pkg::group_t  group_in,
  output yuvrgb_pkg::pixels_t pixels_out
);
  import yuvrgb_pkg::*;

  logic signed [8:0]       u_c;
  logic signed [8:0]       v_c;
  logic signed [SumW-1:0]  chroma_sum;
  logic signed [SumW-1:0]  rounded;
  logic signed [SumW-1:0]  shifted;
  logic signed [CorrW-1:0] corr;
  logic [SampleW-1:0]      luma [NumLuma];
  logic [SampleW-1:0]      red  [NumLuma];
  logic [SampleW-1:0]      green[NumLuma];
  logic [SampleW-1:0]      blue [NumLuma];

  assign u_c = $signed({1'b0, group_in.u_sample}) - CHROMA_BIAS;
  assign v_c = $signed({1'b0, group_in.v_sample}) - CHROMA_BIAS;

  // A zero sum takes the negative rounding offset, as the arithmetic shift floors.
  assign chroma_sum = GAIN_U * SumW'(u_c) + GAIN_V * SumW'(v_c);
  assign rounded    = (chroma_sum > 0) ? chroma_sum + ROUND_HALF : chroma_sum - ROUND_HALF;
  assign shifted    = rounded >>> 16;
  assign corr       = shifted[CorrW-1:0];

  assign luma[0] = group_in.luma_0;
  assign luma[1] = group_in.luma_1;
  assign luma[2] = group_in.luma_2;
  assign luma[3] = group_in.luma_3;

  always_comb begin
    for (int k = 0; k < NumLuma; k++) begin
      red[k]   = clamp_chan($signed({2'b00, luma[k]}) + ChanW'(v_c));
      green[k] = clamp_chan($signed({2'b00, luma[k]}) - ChanW'(corr));
      blue[k]  = clamp_chan($signed({2'b00, luma[k]}) + ChanW'(u_c));
    end
  end

  assign pixels_out.red_0   = red[0];
  assign pixels_out.green_0 = green[0];
  assign pixels_out.blue_0  = blue[0];
  assign pixels_out.red_1   = red[1];
  assign pixels_out.green_1 = green[1];
  assign pixels_out.blue_1  = blue[1];
  assign pixels_out.red_2   = red[2];
  assign pixels_out.green_2 = green[2];
  assign pixels_out.blue_2  = blue[2];
  assign pixels_out.red_3   = red[3];
  assign pixels_out.green_3 = green[3];
  assign pixels_out.blue_3  = blue[3];

endmodule

// File: hw/rtl/yuv411_group_to_rgb.sv
// Top level of the YUV 4:1:1 group to RGB converter with its input and result registers.
//
// The group channel (group_valid, group_ready, group_data) takes one packed group of
// U, Y0, Y1, V, Y2 and Y3 bytes per item. The rgb channel (rgb_valid, rgb_ready, rgb_data)
// gives the four converted pixels of that group as one item, in the same order.
// An accepted group is held in an input register; the conversion logic sits between that
// register and the result register, so a group passes through the input register and
// then the result register before rgb_valid presents it. Throughput is one group per cycle
// while the receiver keeps rgb_ready high. When the receiver stalls, the result register
// holds its item and the input register keeps the next one; group_ready drops only when
// both are full, and the block resumes at full rate as soon as rgb_ready returns. Reset
// empties both registers and holds nothing else.
`timescale 1ns / 1ps

module yuv411_group_to_rgb (
  input  logic                clk,
  input  logic                rst,
  input  logic                group_valid,
  output logic                group_ready,
  input  yuvrgb_pkg::group_t  group_data,
  output logic                rgb_valid,
  input  logic                rgb_ready,
  output yuvrgb_pkg::pixels_t rgb_data
);
  import yuvrgb_pkg::*;

  logic    s1_valid;
  group_t  s1_data;
  pixels_t conv_data;
  logic    s1_advance;

  assign s1_advance  = s1_valid && (!rgb_valid || rgb_ready);
  assign group_ready = !s1_valid || s1_advance;

  yuvrgb_convert u_convert (
    .group_in   (s1_data),
    .pixels_out (conv_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (group_ready) begin
        s1_valid <= group_valid;
      end
      if (s1_advance) begin
        rgb_valid <= 1'b1;
      end else if (rgb_ready) begin
        rgb_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (group_valid && group_ready) begin
      s1_data <= group_data;
    end
    if (s1_advance) begin
      rgb_data <= conv_data;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !s1_valid && !rgb_valid)
    else $error("pipeline not empty after reset");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    group_valid && group_ready |=> s1_valid)
    else $error("accepted group not held in the input register");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> rgb_valid)
    else $error("converted item not presented");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rgb_valid && !rgb_ready |-> !group_ready)
    else $error("group accepted while both registers are full");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |=> rgb_valid)
    else $error("stalled result dropped");

endmodule
